// File: rtl/fifs_pkg.sv
// Package for the float integer/fraction split block.
// Holds payload types and shared constants; no dependencies.
package fifs_pkg;

  localparam int DataW = 64;

  // Precision codes carried in the operation field.
  localparam logic OpDouble = 1'b0;
  localparam logic OpSingle = 1'b1;

  // Input beat payload.
  typedef struct packed {
    logic             operation;
    logic [DataW-1:0] value_bits;
  } in_beat_t;

  // Output beat payload.
  typedef struct packed {
    logic [DataW-1:0] integer_bits;
    logic [DataW-1:0] fraction_bits;
  } out_beat_t;

  // Classified item passed from the front part to the back part.
  typedef struct packed {
    logic             single;
    logic             done;      // result already fully formed
    logic [DataW-1:0] ipart;     // integer part, final
    logic [DataW-1:0] fpart;     // final fraction when done
    logic [DataW-1:0] rest;      // unnormalized fraction mantissa bits
    logic [10:0]      expo;      // input biased exponent
    logic             sign;
  } work_t;

endpackage

// File: rtl/fifs_if.sv
// Valid/ready channel interfaces for the float split block.
// Depends on fifs_pkg.
interface fifs_in_if import fifs_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface fifs_out_if import fifs_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/float_integer_fraction_split_top.sv
// Top level of the IEEE 754 integer/fraction split block.
// Depends on fifs_pkg, fifs_if, fifs_front, fifs_queue and fifs_back.
//
// Splits a double, or a single in the low 32 bits, into its integer part and
// exact fraction, one beat per cycle sustained while the output is not stalled.
// An accepted beat is registered in the front register, then written to the
// queue, then captured in the result register. The two-entry queue lets either
// side stall on its own.
module float_integer_fraction_split_top import fifs_pkg::*; (
  input logic       clk,
  input logic       rst,
  fifs_in_if.sink   in_ch,
  fifs_out_if.source out_ch
);

  logic  f_valid, f_ready, q_valid, q_ready;
  work_t f_data, q_data;

  fifs_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_data (in_ch.data),
    .wk_valid (f_valid), .wk_ready (f_ready), .wk_data (f_data)
  );

  fifs_queue u_queue (
    .clk, .rst,
    .wr_valid (f_valid), .wr_ready (f_ready), .wr_data (f_data),
    .rd_valid (q_valid), .rd_ready (q_ready), .rd_data (q_data)
  );

  fifs_back u_back (
    .clk, .rst,
    .wk_valid (q_valid), .wk_ready (q_ready), .wk_data (q_data),
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_data (out_ch.data)
  );

  // A single-precision result never carries upper bits.
  a_single_upper: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_data.single) |=>
      (out_ch.data.integer_bits[63:32] == 32'd0 &&
       out_ch.data.fraction_bits[63:32] == 32'd0))
    else $error("single result has upper bits set");

  // A beat handed to the back part shows as output in the next cycle.
  a_back_valid: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |=> out_ch.valid)
    else $error("back part lost a beat");

  // The queue always reports data while it is full and stalls the front.
  a_queue_flow: assert property (@(posedge clk) disable iff (rst)
    (!f_ready) |-> q_valid)
    else $error("queue full yet empty");

endmodule

// File: rtl/fifs_front.sv
// Front part: accepts a beat, classifies the value and forms the integer part.
// Depends on fifs_pkg.
module fifs_front import fifs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  output logic     wk_valid,
  input  logic     wk_ready,
  output work_t    wk_data
);

  work_t cls;

  // Classification per precision, combinational.
  always_comb begin
    logic [63:0] x, below, mmask;
    logic [10:0] expo, emax, bias;
    logic [5:0]  mb, e;
    logic        sign, mzero;
    x = in_data.value_bits;
    if (in_data.operation == OpSingle) begin
      x = {32'd0, in_data.value_bits[31:0]};
      mb = 6'd23;
      emax = 11'd255;
      bias = 11'd127;
      expo = {3'd0, x[30:23]};
      sign = x[31];
      mmask = 64'h7F_FFFF;
    end else begin
      mb = 6'd52;
      emax = 11'h7FF;
      bias = 11'd1023;
      expo = x[62:52];
      sign = x[63];
      mmask = 64'h000F_FFFF_FFFF_FFFF;
    end
    mzero = (x & mmask) == 64'd0;
    e = 6'(expo - bias);
    below = mmask >> e;
    cls.single = in_data.operation == OpSingle;
    cls.expo = expo;
    cls.sign = sign;
    cls.rest = x & below;
    cls.done = 1'b1;
    cls.ipart = x;
    cls.fpart = 64'd0;
    if (expo == emax) begin
      if (!mzero) begin
        cls.ipart = x | (64'd1 << (mb - 6'd1));
        cls.fpart = cls.ipart;
      end
    end else if (expo >= bias + {5'd0, mb}) begin
      cls.fpart = 64'd0;
    end else if (expo < bias) begin
      cls.ipart = (expo == 11'd0 && mzero) ? 64'd0
                  : (cls.single ? {32'd0, sign, 31'd0} : {sign, 63'd0});
      cls.fpart = x;
    end else if ((x & below) != 64'd0) begin
      cls.ipart = x & ~below;
      cls.done = 1'b0;
    end
  end

  // Output register; accepts whenever the register is empty or drains.
  assign in_ready = !wk_valid || wk_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wk_valid <= 1'b0;
    end else if (in_ready) begin
      wk_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      wk_data <= cls;
    end
  end

endmodule

// File: rtl/fifs_queue.sv
// Two-entry queue between the front and back parts.
// Depends on fifs_pkg.
module fifs_queue import fifs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  work_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output work_t rd_data
);

  work_t      mem [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = mem[rptr];

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) wptr <= !wptr;
      if (rd_valid && rd_ready) rptr <= !rptr;
      count <= count + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem[wptr] <= wr_data;
    end
  end

endmodule

// File: rtl/fifs_back.sv
// Back part: normalizes the fraction and registers the result beat.
// Depends on fifs_pkg.
module fifs_back import fifs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      wk_valid,
  output logic      wk_ready,
  input  work_t     wk_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  out_beat_t res;

  // Leading-one search and normalization of the fraction mantissa.
  always_comb begin
    logic [5:0]  lz, mb;
    logic [63:0] norm;
    logic [10:0] fexp;
    mb = wk_data.single ? 6'd23 : 6'd52;
    lz = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (wk_data.rest[i] && 6'(i) <= mb) lz = mb - 6'(i);
    end
    norm = wk_data.rest << lz;
    fexp = wk_data.expo - {5'd0, lz};
    res.integer_bits = wk_data.ipart;
    if (wk_data.done) begin
      res.fraction_bits = wk_data.fpart;
    end else if (wk_data.single) begin
      res.fraction_bits = {32'd0, wk_data.sign, fexp[7:0], norm[22:0]};
    end else begin
      res.fraction_bits = {wk_data.sign, fexp, norm[51:0]};
    end
  end

  assign wk_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wk_ready) begin
      out_valid <= wk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wk_ready && wk_valid) begin
      out_data <= res;
    end
  end

endmodule

// File: dv/fifs_checker.sv
// Checker for the float integer/fraction split block: predicts each result
// from the accepted input beats and compares it with the output beats.
// Depends on fifs_pkg and fifs_if.
module fifs_checker import fifs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  fifs_in_if          in_ch,
  fifs_out_if         out_ch,
  output int unsigned failures,
  output int unsigned pending,
  output int unsigned accepted_out
);

  out_beat_t split_queue[$];

  // Split one value of the given format into integer part and fraction.
  function automatic void split_float(input logic [63:0] x, input int mb, input int eb,
                                      output logic [63:0] ipart,
                                      output logic [63:0] fpart);
    logic [63:0] mmask, emax, bias, sign, expo, mant, below, rest;
    int shift;
    mmask = (64'd1 << mb) - 64'd1;
    emax = (64'd1 << eb) - 64'd1;
    bias = emax >> 1;
    sign = x & (64'd1 << (mb + eb));
    expo = (x >> mb) & emax;
    mant = x & mmask;
    if (expo == emax) begin
      if (mant != 0) begin
        ipart = x | (64'd1 << (mb - 1));
        fpart = ipart;
      end else begin
        ipart = x;
        fpart = 0;
      end
    end else if (expo >= bias + mb) begin
      ipart = x;
      fpart = 0;
    end else if (expo < bias) begin
      ipart = (expo == 0 && mant == 0) ? 64'd0 : sign;
      fpart = x;
    end else begin
      below = mmask >> (expo - bias);
      rest = mant & below;
      if (rest == 0) begin
        ipart = x;
        fpart = 0;
      end else begin
        ipart = x & ~below;
        shift = 0;
        // Normalize the leftover bits up to the hidden bit position.
        while (rest[mb] == 1'b0) begin
          rest = rest << 1;
          shift++;
        end
        fpart = sign | ((expo - shift) << mb) | (rest & mmask);
      end
    end
  endfunction

  function automatic out_beat_t predict_split(input in_beat_t b);
    out_beat_t r;
    logic [63:0] ip, fp;
    if (b.operation == OpSingle) begin
      split_float({32'd0, b.value_bits[31:0]}, 23, 8, ip, fp);
      ip[63:32] = '0;
      fp[63:32] = '0;
    end else begin
      split_float(b.value_bits, 52, 11, ip, fp);
    end
    r.integer_bits = ip;
    r.fraction_bits = fp;
    return r;
  endfunction

  assign pending = split_queue.size();

  // Predict on input beats and compare on output beats.
  always @(posedge clk) begin
    out_beat_t want;
    int unsigned errs;
    errs = 0;
    if (rst) begin
      failures <= 0;
      accepted_out <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) split_queue.push_back(predict_split(in_ch.data));
      if (out_ch.valid && out_ch.ready) begin
        accepted_out <= accepted_out + 1;
        if (split_queue.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_ch.data);
          errs++;
        end else begin
          want = split_queue.pop_front();
          if (want.integer_bits !== out_ch.data.integer_bits) begin
            $display("%0t: integer_bits expected %h actual %h", $time,
                     want.integer_bits, out_ch.data.integer_bits);
            errs++;
          end
          if (want.fraction_bits !== out_ch.data.fraction_bits) begin
            $display("%0t: fraction_bits expected %h actual %h", $time,
                     want.fraction_bits, out_ch.data.fraction_bits);
            errs++;
          end
        end
        if (errs != 0) failures <= failures + errs;
      end
    end
  end

endmodule

// File: dv/testbench.sv
// Top of the float integer/fraction split testbench: clock, reset, stimulus
// and verdict. Depends on fifs_pkg, fifs_if, fifs_checker and the RTL top.
module testbench;
  import fifs_pkg::*;

  localparam int NumRandom = 850;
  localparam int IdleLimit = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int unsigned failures, pending, accepted_out;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;

  fifs_in_if  in_ch (clk);
  fifs_out_if out_ch (clk);

  float_integer_fraction_split_top u_top (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  fifs_checker u_checker (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .failures(failures), .pending(pending), .accepted_out(accepted_out)
  );

  always #2 clk = ~clk;

  // Send one beat after a random gap and wait for it to be taken.
  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_beat(input logic op, input logic [63:0] v);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data.operation <= op;
    in_ch.data.value_bits <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Random double with an exponent mostly near the binary point.
  function automatic logic [63:0] random_double();
    logic [63:0] v;
    int e;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0, 1, 2: e = 1023 + $urandom_range(0, 52) - 3;
      3: e = 1023 + $urandom_range(0, 52) - 3;
      default: e = $urandom_range(0, 2047);
    endcase
    v[62:52] = e[10:0];
    if ($urandom_range(0, 7) == 0) v[51:0] = v[51:0] & ({52{1'b1}} << $urandom_range(0, 52));
    return v;
  endfunction

  function automatic logic [63:0] random_single();
    logic [63:0] v;
    int e;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      e = 127 + $urandom_range(0, 23) - 2;
      v[30:23] = e[7:0];
    end
    if ($urandom_range(0, 7) == 0) v[22:0] = v[22:0] & ({23{1'b1}} << $urandom_range(0, 23));
    return v;
  endfunction

  // Output side stalls at random.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 9);
      if (sent > 300 && sent < 400) stall = 0;
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Directed extremes and special cases.
    send_beat(OpDouble, 64'h0000000000000000);  // +0
    send_beat(OpDouble, 64'h8000000000000000);  // -0
    send_beat(OpDouble, 64'h7FF0000000000000);  // +inf
    send_beat(OpDouble, 64'hFFF0000000000000);  // -inf
    send_beat(OpDouble, 64'h7FF0000000000001);  // signaling NaN
    send_beat(OpDouble, 64'hFFFFFFFFFFFFFFFF);  // quiet NaN, all ones
    send_beat(OpDouble, 64'h4330000000000000);  // 2^52
    send_beat(OpDouble, 64'h432FFFFFFFFFFFFF);  // just below 2^52
    send_beat(OpDouble, 64'hC008000000000000);  // -3.0, negative integer
    send_beat(OpDouble, 64'hC00C000000000000);  // -3.5
    send_beat(OpDouble, 64'h3FF0000000000001);  // 1 plus one ulp
    send_beat(OpDouble, 64'h3FEFFFFFFFFFFFFF);  // just below one
    send_beat(OpDouble, 64'h800FFFFFFFFFFFFF);  // negative subnormal
    send_beat(OpSingle, 64'hFFFFFFFF00000000);  // +0 with junk upper bits
    send_beat(OpSingle, 64'h0000000080000000);  // -0
    send_beat(OpSingle, 64'h000000007F800000);  // +inf
    send_beat(OpSingle, 64'hABCDEF01FF800001);  // signaling NaN
    send_beat(OpSingle, 64'h000000004B000000);  // 2^23
    send_beat(OpSingle, 64'h000000004AFFFFFF);  // just below 2^23
    send_beat(OpSingle, 64'h00000000C0600000);  // -3.5
    send_beat(OpSingle, 64'h00000000C0400000);  // -3.0
    send_beat(OpSingle, 64'h000000003F800001);  // 1 plus one ulp
    send_beat(OpSingle, 64'h00000000007FFFFF);  // subnormal
    // Random mix of both precisions.
    repeat (NumRandom) begin
      if ($urandom_range(0, 1) == 0) send_beat(OpDouble, random_double());
      else send_beat(OpSingle, random_single());
    end
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d beats in both precisions, %0d results checked.", sent, accepted_out);
    if (failures == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
